/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL of the spherical-coordinate core.
// Depends on nothing; files that assert include it by bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define C2S_ASSERT(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("c2s assertion failed");

// Implication checked at every clock edge out of reset.
`define C2S_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("c2s assertion failed");

`endif

/* rtl/core/c2s_pkg.sv */
// Package for the spherical-coordinate core: widths, cell word types,
// atan table and helper functions. Depends on nothing.
`default_nettype none

package c2s_pkg;

    localparam int CORDIC_STAGES = 20;
    localparam int CORDIC_RUN    = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
    localparam int SQRT_CELLS    = 32;
    localparam int CW            = 44;   // CORDIC x/y datapath
    localparam int AW            = 36;   // angle accumulator, 30 fraction bits

    localparam logic signed [AW-1:0] PI30 = 36'sd3373259426;
    localparam logic signed [21:0]   HI22 = 22'sd205887;
    localparam logic signed [21:0]   LO22 = -22'sd205887;

    localparam logic [29:0] ATAN_TAB [32] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
        30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
        30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
        30'd262144,    30'd131072,    30'd65536,     30'd32768,
        30'd16384,     30'd8192,      30'd4096,      30'd2048,
        30'd1024,      30'd512,       30'd256,       30'd128,
        30'd64,        30'd32,        30'd16,        30'd8,
        30'd4,         30'd2,         30'd1,         30'd0
    };

    typedef struct packed {
        logic signed [CW-1:0] a;
        logic signed [CW-1:0] b;
        logic signed [AW-1:0] ang;
        logic                 zr;
    } cordic_t;

    typedef struct packed {
        logic [63:0] rad;
        logic [34:0] rem;
        logic [31:0] root;
    } sqrt_t;

    function automatic logic [AW-1:0] atan_val(input logic [4:0] i);
        return {{(AW-30){1'b0}}, ATAN_TAB[i]};
    endfunction

    // index of highest set bit, 0 for zero
    function automatic logic [4:0] msb32(input logic [31:0] v);
        logic [4:0] r;
        r = '0;
        for (int k = 0; k < 32; k++) begin
            if (v[k]) r = 5'(k);
        end
        return r;
    endfunction

    // round 30-frac angle to 16-frac, ties up, then clamp
    function automatic logic signed [18:0] sat_q16(input logic signed [AW-1:0] ang,
                                                   input logic allow_neg);
        logic signed [AW-1:0] t;
        logic signed [21:0]   r;
        logic signed [21:0]   lo;
        t  = ang + AW'(8192);
        r  = t[AW-1:14];
        lo = allow_neg ? LO22 : 22'sd0;
        if (r > HI22) r = HI22;
        if (r < lo) r = lo;
        return 19'(r);
    endfunction

endpackage

`default_nettype wire

/* rtl/core/c2s_sqrt_cell.sv */
// One radix-2 restoring square-root cell: one root bit per cell.
// Depends on c2s_pkg.
`default_nettype none

module c2s_sqrt_cell import c2s_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  en,
    input  wire sqrt_t c_in,
    output sqrt_t      c_out_reg
);

    sqrt_t       c_next;
    logic [34:0] rsh;
    logic [35:0] diff;

    always_comb begin
        rsh  = {c_in.rem[32:0], c_in.rad[63:62]};
        diff = {1'b0, rsh} - {2'b00, c_in.root, 2'b01};
        c_next.rad = {c_in.rad[61:0], 2'b00};
        if (!diff[35]) begin
            c_next.rem  = diff[34:0];
            c_next.root = {c_in.root[30:0], 1'b1};
        end else begin
            c_next.rem  = rsh;
            c_next.root = {c_in.root[30:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) c_out_reg <= c_next;
    end

endmodule

`default_nettype wire

/* rtl/core/c2s_cordic_cell.sv */
// One vectoring CORDIC micro-rotation cell with its own shift and atan step.
// Depends on c2s_pkg.
`default_nettype none

module c2s_cordic_cell import c2s_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       en,
    input  wire logic [4:0] idx,
    input  wire cordic_t    c_in,
    output cordic_t         c_out_reg
);

    cordic_t              c_next;
    logic signed [CW-1:0] da;
    logic signed [CW-1:0] db;
    logic [AW-1:0]        step;

    always_comb begin
        da   = $signed(c_in.b) >>> idx;
        db   = $signed(c_in.a) >>> idx;
        step = atan_val(idx);
        c_next.zr = c_in.zr;
        if (!c_in.b[CW-1]) begin
            c_next.a   = c_in.a + da;
            c_next.b   = c_in.b - db;
            c_next.ang = c_in.ang + $signed(step);
        end else begin
            c_next.a   = c_in.a - da;
            c_next.b   = c_in.b + db;
            c_next.ang = c_in.ang - $signed(step);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) c_out_reg <= c_next;
    end

endmodule

`default_nettype wire

/* rtl/core/cartesian_to_spherical_core.sv */
// Top level of the spherical-coordinate core: pipelined radius, azimuth
// and polar angle. Depends on c2s_pkg, c2s_sqrt_cell, c2s_cordic_cell.
//
//  channel | ports                                   | flow
//  --------+-----------------------------------------+------------------
//  input   | s_valid s_ready s_coord_x/y/z           | one point per word
//  result  | m_valid m_ready m_radius m_polar_angle  | one word per point
//          | m_azimuth m_zero_vector                 |
//
// One word per clock sustained while the result register is not stalled. The pipe depth is
// set by the 32-cell square-root chain feeding the polar CORDIC chain.
// Reset clears only the valid and zero-flag chains; the data pipe needs none.
// The whole pipe advances together; it stalls only when the result register
// is full and m_ready is low, and s_ready follows that same enable.
`default_nettype none
`include "assert_macros.svh"

module cartesian_to_spherical_core import c2s_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [31:0] s_coord_x,
    input  wire logic signed [31:0] s_coord_y,
    input  wire logic signed [31:0] s_coord_z,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [31:0]             m_radius,
    output logic [17:0]             m_polar_angle,
    output logic signed [18:0]      m_azimuth,
    output logic                    m_zero_vector
);

    localparam int LAT    = 38 + CORDIC_RUN;
    localparam int RAD_DL = 3 + CORDIC_RUN;
    localparam int AZ_DL  = 36;

    logic en;

    // valid and zero flag ride a chain the full depth of the pipe
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] zero_reg;

    assign m_valid = vld_reg[LAT-1];
    assign en      = !vld_reg[LAT-1] || m_ready;
    assign s_ready = en;

    // ---------------- stage 1: magnitudes, quadrant fold, shift amounts
    logic [31:0]        ax, ay, az, pm, bm, am, zm;
    logic [32:0]        a1, b1;
    logic [AW-1:0]      off1;
    logic [4:0]         s1;
    logic [5:0]         sh1;
    logic               zero_in;

    always_comb begin
        ax = s_coord_x[31] ? 32'(-{s_coord_x[31], s_coord_x}) : s_coord_x;
        ay = s_coord_y[31] ? 32'(-{s_coord_y[31], s_coord_y}) : s_coord_y;
        az = s_coord_z[31] ? 32'(-{s_coord_z[31], s_coord_z}) : s_coord_z;
        zero_in = (s_coord_x == 32'sd0) && (s_coord_y == 32'sd0) && (s_coord_z == 32'sd0);

        // azimuth: left half plane folded by a half turn
        if (s_coord_x[31]) begin
            a1   = -{s_coord_x[31], s_coord_x};
            b1   = -{s_coord_y[31], s_coord_y};
            off1 = s_coord_y[31] ? -PI30 : PI30;
        end else begin
            a1   = {s_coord_x[31], s_coord_x};
            b1   = {s_coord_y[31], s_coord_y};
            off1 = '0;
        end
        am  = a1[31:0];
        bm  = b1[32] ? 32'(-b1) : b1[31:0];
        zm  = (am > bm) ? am : bm;
        sh1 = 6'd39 - {1'b0, msb32(zm)};

        // polar: normalize largest magnitude to [2^30, 2^31]
        pm = (ax > ay) ? ax : ay;
        if (az > pm) pm = az;
        s1 = (pm[31] || pm[30]) ? 5'd0 : (5'd30 - msb32(pm));
    end

    logic [31:0]        ax_reg, ay_reg, az_reg;
    logic signed [31:0] z1_reg;
    logic [4:0]         s_reg;
    logic [32:0]        a1_reg, b1_reg;
    logic [AW-1:0]      off1_reg;
    logic [5:0]         sh1_reg;
    logic               azz_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ax_reg   <= ax;
            ay_reg   <= ay;
            az_reg   <= az;
            z1_reg   <= s_coord_z;
            s_reg    <= s1;
            a1_reg   <= a1;
            b1_reg   <= b1;
            off1_reg <= off1;
            sh1_reg  <= sh1;
            azz_reg  <= (zm == 32'd0);
        end
    end

    // ---------------- stage 2: squares, scaled polar terms, azimuth CORDIC load
    logic [31:0]        sxa, sya;
    logic [63:0]        rx2_reg, ry2_reg, rz2_reg, px2_reg, py2_reg;
    logic signed [32:0] zn2_reg;
    cordic_t            az_in_reg;

    assign sxa = ax_reg << s_reg;
    assign sya = ay_reg << s_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            rx2_reg       <= 64'(ax_reg) * 64'(ax_reg);
            ry2_reg       <= 64'(ay_reg) * 64'(ay_reg);
            rz2_reg       <= 64'(az_reg) * 64'(az_reg);
            px2_reg       <= 64'(sxa) * 64'(sxa);
            py2_reg       <= 64'(sya) * 64'(sya);
            zn2_reg       <= $signed({z1_reg[31], z1_reg}) <<< s_reg;
            az_in_reg.a   <= $signed({{(CW-33){a1_reg[32]}}, a1_reg}) <<< sh1_reg;
            az_in_reg.b   <= $signed({{(CW-33){b1_reg[32]}}, b1_reg}) <<< sh1_reg;
            az_in_reg.ang <= $signed(off1_reg);
            az_in_reg.zr  <= azz_reg;
        end
    end

    // ---------------- stage 3: sums into the two square-root chains
    sqrt_t              rad_in_reg, rho_in_reg;
    logic signed [32:0] zn_dly_reg [SQRT_CELLS+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_in_reg.rad  <= rx2_reg + ry2_reg + rz2_reg;
            rad_in_reg.rem  <= '0;
            rad_in_reg.root <= '0;
            rho_in_reg.rad  <= px2_reg + py2_reg;
            rho_in_reg.rem  <= '0;
            rho_in_reg.root <= '0;
            zn_dly_reg[0]   <= zn2_reg;
            for (int k = 1; k <= SQRT_CELLS; k++) zn_dly_reg[k] <= zn_dly_reg[k-1];
        end
    end

    sqrt_t rad_c [SQRT_CELLS+1];
    sqrt_t rho_c [SQRT_CELLS+1];
    assign rad_c[0] = rad_in_reg;
    assign rho_c[0] = rho_in_reg;

    for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
        c2s_sqrt_cell u_rad (.aclk(aclk), .en(en), .c_in(rad_c[i]), .c_out_reg(rad_c[i+1]));
        c2s_sqrt_cell u_rho (.aclk(aclk), .en(en), .c_in(rho_c[i]), .c_out_reg(rho_c[i+1]));
    end

    // ---------------- azimuth CORDIC chain, then delay to output alignment
    cordic_t az_c [CORDIC_RUN+1];
    assign az_c[0] = az_in_reg;

    for (genvar i = 0; i < CORDIC_RUN; i++) begin : g_az
        c2s_cordic_cell u_cell (
            .aclk(aclk), .en(en), .idx(5'(i)), .c_in(az_c[i]), .c_out_reg(az_c[i+1])
        );
    end

    logic signed [18:0] az_q;
    logic signed [18:0] az_dly_reg [AZ_DL];

    assign az_q = az_c[CORDIC_RUN].zr ? 19'sd0 : sat_q16(az_c[CORDIC_RUN].ang, 1'b1);

    always_ff @(posedge aclk) begin
        if (en) begin
            az_dly_reg[0] <= az_q;
            for (int k = 1; k < AZ_DL; k++) az_dly_reg[k] <= az_dly_reg[k-1];
        end
    end

    // ---------------- polar: fold and normalize (rho, z), then CORDIC
    logic [31:0]        rho;
    logic signed [32:0] zn, pa, pb;
    logic [31:0]        pam, pmx;
    logic [AW-1:0]      poff;
    logic [5:0]         psh;

    always_comb begin
        rho = rho_c[SQRT_CELLS].root;
        zn  = zn_dly_reg[SQRT_CELLS];
        if (zn[32]) begin
            pa   = -zn;
            pb   = -{1'b0, rho};
            poff = PI30;
        end else begin
            pa   = zn;
            pb   = {1'b0, rho};
            poff = '0;
        end
        pam = pa[31:0];
        pmx = (pam > rho) ? pam : rho;
        psh = 6'd39 - {1'b0, msb32(pmx)};
    end

    logic [32:0]   pa_reg, pb_reg;
    logic [AW-1:0] poff_reg;
    logic [5:0]    psh_reg;
    cordic_t       pol_in_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            pa_reg         <= pa;
            pb_reg         <= pb;
            poff_reg       <= poff;
            psh_reg        <= psh;
            pol_in_reg.a   <= $signed({{(CW-33){pa_reg[32]}}, pa_reg}) <<< psh_reg;
            pol_in_reg.b   <= $signed({{(CW-33){pb_reg[32]}}, pb_reg}) <<< psh_reg;
            pol_in_reg.ang <= $signed(poff_reg);
            pol_in_reg.zr  <= 1'b0;
        end
    end

    cordic_t pol_c [CORDIC_RUN+1];
    assign pol_c[0] = pol_in_reg;

    for (genvar i = 0; i < CORDIC_RUN; i++) begin : g_pol
        c2s_cordic_cell u_cell (
            .aclk(aclk), .en(en), .idx(5'(i)), .c_in(pol_c[i]), .c_out_reg(pol_c[i+1])
        );
    end

    // ---------------- radius delay and result register
    logic [31:0]        rad_dly_reg [RAD_DL];
    logic signed [18:0] pol_q;
    logic [17:0]        pol_reg;

    assign pol_q = sat_q16(pol_c[CORDIC_RUN].ang, 1'b0);

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_dly_reg[0] <= rad_c[SQRT_CELLS].root;
            for (int k = 1; k < RAD_DL; k++) rad_dly_reg[k] <= rad_dly_reg[k-1];
            pol_reg <= zero_reg[LAT-2] ? 18'd0 : pol_q[17:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            zero_reg <= '0;
        end else if (en) begin
            vld_reg  <= {vld_reg[LAT-2:0], s_valid};
            zero_reg <= {zero_reg[LAT-2:0], zero_in};
        end
    end

    assign m_radius      = rad_dly_reg[RAD_DL-1];
    assign m_polar_angle = pol_reg;
    assign m_azimuth     = az_dly_reg[AZ_DL-1];
    assign m_zero_vector = zero_reg[LAT-1];

    // ---------------- checks
    `C2S_ASSERT_IMP(a_zero_all, aclk, aresetn, m_valid && m_zero_vector,
        m_radius == 32'd0 && m_polar_angle == 18'd0 && m_azimuth == 19'sd0)
    `C2S_ASSERT_IMP(a_polar_rng, aclk, aresetn, m_valid, m_polar_angle <= 18'd205887)
    `C2S_ASSERT_IMP(a_az_rng, aclk, aresetn, m_valid,
        m_azimuth <= 19'sd205887 && m_azimuth >= -19'sd205887)
    `C2S_ASSERT_IMP(a_stall_hold, aclk, aresetn, m_valid && !m_ready,
        ##1 ($stable(m_radius) && $stable(m_azimuth) && $stable(m_polar_angle)))

endmodule

`default_nettype wire
